// File: sv/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg: shared types and constants of the wildcard pattern matcher
// Pattern bound, position widths, command and queue operation codes, and the
// layout of one queue entry passed from the front end to the back end.
// ----------------------------------------------------------------------------
package wpm_pkg;

    // pattern storage bound and derived widths
    localparam int PATTERN_MAX = 16;
    localparam int POS_W       = PATTERN_MAX + 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int IDX_W       = $clog2(PATTERN_MAX);

    // active set after a rearm: only position zero
    localparam logic [POS_W-1:0] REARM_SET = POS_W'(1);

    // decoupling queue, depth is a power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // special pattern bytes
    localparam logic [7:0] SYM_STAR = 8'h2A;
    localparam logic [7:0] SYM_ANY  = 8'h2E;

    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_APPEND  = 2'd1,
        CMD_SUBJECT = 2'd2,
        CMD_END     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        OP_REARM  = 2'd0,
        OP_STEP   = 2'd1,
        OP_FINISH = 2'd2
    } op_t;

    // one classified item, as the back end consumes it
    typedef struct packed {
        op_t              op;
        logic             overflow;
        logic [LEN_W-1:0] len;
        logic [POS_W-1:0] star;
        logic [POS_W-1:0] hit;
    } qentry_t;

    // queue head status towards the back end
    typedef struct packed {
        logic    valid;
        qentry_t entry;
    } qhead_t;

endpackage

// File: sv/wpm_front.sv
// ----------------------------------------------------------------------------
// wpm_front: command intake and classification
// Holds the pattern, its length and the overflow flag. Every accepted beat
// becomes one queue entry: a rearm, a step with its per-position hit and star
// masks, or a finish carrying the length and overflow flag.
// ----------------------------------------------------------------------------
module wpm_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [7:0] symbol
    input  logic [1:0]       s_axis_tuser,   // [1:0] command
    input  logic             q_full,
    output logic             q_push,
    output wpm_pkg::qentry_t q_entry
);
    import wpm_pkg::*;

    logic [7:0]       pattern_reg [PATTERN_MAX];
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic             overflow_reg;
    logic             overflow_next;

    cmd_t             cmd;
    logic             accept;
    logic             room;
    logic [POS_W-1:0] star_mask;
    logic [POS_W-1:0] hit_mask;

    assign cmd           = cmd_t'(s_axis_tuser);
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;
    assign room          = len_reg < LEN_W'(PATTERN_MAX);

    // per-position star and hit masks for the stored prefix
    always_comb
    begin
        star_mask = '0;
        hit_mask  = '0;
        for (int p = 0; p < PATTERN_MAX; p++)
        begin
            if (LEN_W'(p) < len_reg)
            begin
                if (pattern_reg[p] == SYM_STAR)
                    star_mask[p] = 1'b1;
                else if (pattern_reg[p] == SYM_ANY || pattern_reg[p] == s_axis_tdata)
                    hit_mask[p] = 1'b1;
            end
        end
    end

    // pattern length and overflow update
    always_comb
    begin
        len_next      = len_reg;
        overflow_next = overflow_reg;
        if (accept)
        begin
            unique case (cmd)
                CMD_CLEAR:
                begin
                    len_next      = '0;
                    overflow_next = 1'b0;
                end
                CMD_APPEND:
                begin
                    if (room)
                        len_next = len_reg + LEN_W'(1);
                    else
                        overflow_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    // entry build
    always_comb
    begin
        q_push            = accept;
        q_entry.overflow  = overflow_reg;
        q_entry.len       = len_reg;
        q_entry.star      = star_mask;
        q_entry.hit       = hit_mask;
        unique case (cmd)
            CMD_SUBJECT: q_entry.op = OP_STEP;
            CMD_END:     q_entry.op = OP_FINISH;
            default:     q_entry.op = OP_REARM;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            len_reg      <= len_next;
            overflow_reg <= overflow_next;
        end
    end

    // pattern byte store, no reset
    always_ff @(posedge clk)
    begin
        if (accept && cmd == CMD_APPEND && room)
            pattern_reg[len_reg[IDX_W-1:0]] <= s_axis_tdata;
    end

endmodule

// File: sv/wpm_queue.sv
// ----------------------------------------------------------------------------
// wpm_queue: short entry queue between front and back end
// Small flip-flop fifo; the head is visible combinationally to the back end.
// ----------------------------------------------------------------------------
module wpm_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  wpm_pkg::qentry_t push_entry,
    output logic             full,
    input  logic             pop,
    output wpm_pkg::qhead_t  head
);
    import wpm_pkg::*;

    qentry_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full       = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.entry = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

// File: sv/wpm_back.sv
// ----------------------------------------------------------------------------
// wpm_back: active-set engine and result register
// Applies star closure and one subject step per entry to the bit-parallel
// active set, and loads the result register on each finish.
// ----------------------------------------------------------------------------
module wpm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  wpm_pkg::qhead_t head,
    output logic            pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] matched, [1] pattern_overflow
);
    import wpm_pkg::*;

    logic [POS_W-1:0] active_reg;
    logic [POS_W-1:0] active_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             matched_reg;
    logic             matched_next;
    logic             overflow_reg;
    logic             overflow_next;

    logic             slot_free;
    logic [POS_W-1:0] gen;
    logic [POS_W-1:0] fill;
    logic [POS_W-1:0] closed;

    // star closure as a carry chain: active stars generate, stars propagate
    assign gen    = active_reg & head.entry.star;
    assign fill   = (head.entry.star + gen) ^ head.entry.star ^ gen;
    assign closed = active_reg | fill;

    assign slot_free = !out_valid_reg || m_axis_tready;
    assign pop       = head.valid && (head.entry.op != OP_FINISH || slot_free);

    // active set and result update
    always_comb
    begin
        active_next    = active_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        matched_next   = matched_reg;
        overflow_next  = overflow_reg;
        if (pop)
        begin
            unique case (head.entry.op)
                OP_REARM:
                    active_next = REARM_SET;
                OP_STEP:
                    active_next = (closed & head.entry.star)
                                | ((closed & head.entry.hit) << 1);
                OP_FINISH:
                begin
                    active_next    = REARM_SET;
                    out_valid_next = 1'b1;
                    matched_next   = closed[head.entry.len];
                    overflow_next  = head.entry.overflow;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= REARM_SET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        matched_reg  <= matched_next;
        overflow_reg <= overflow_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, overflow_reg, matched_reg};

endmodule

// File: sv/wildcard_pattern_matcher_core.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher_core: whole-string glob matcher
// Input beats carry a command in s_axis_tuser (clear pattern, append pattern
// byte, subject byte, end of subject) and a byte in s_axis_tdata. In the
// pattern '.' matches any byte and '*' any run of bytes, empty runs included.
// Only an end-of-subject beat produces an output beat, with the whole-subject
// match bit and the sticky pattern overflow flag; the active set is then
// rearmed. Clear and append beats also rearm it.
// One beat is taken every cycle while the queue is not full. The front end
// turns each beat into a queue entry in the cycle it arrives; the back end
// retires one entry a cycle, a finish only while the output slot is free,
// applying a carry-chain star closure and a bit-parallel step to the active
// set. A finish passes through a queue slot, then the output register, to
// m_axis_tvalid. When the receiver stalls, the result waits in the output
// register, the two-entry queue absorbs further beats and s_axis_tready
// drops only once the queue is full. Reset empties the pattern, clears the
// overflow flag, the queue and the output valid flag and arms position zero;
// pattern bytes keep no reset value and are read only once written.
module wildcard_pattern_matcher_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] symbol
    input  logic [1:0] s_axis_tuser,    // [1:0] command
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata     // [0] matched, [1] pattern_overflow, rest zero
);
    import wpm_pkg::*;

    logic    q_full;
    logic    q_push;
    logic    q_pop;
    qentry_t q_entry;
    qhead_t  q_head;

    // beat intake and classification
    wpm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_entry       (q_entry)
    );

    // decoupling queue
    wpm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head       (q_head)
    );

    // active-set engine and result register
    wpm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .pop           (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
